@@ hw/rtl/bkbb_pkg.sv @@
package bkbb_pkg;

    localparam int W_W     = 16;
    localparam int V_W     = 16;
    localparam int L_W     = 8;
    localparam int CAP_W   = 24;
    localparam int TV_W    = 30;
    localparam int POS_W   = 6;
    localparam int IT_W    = W_W + V_W + L_W;
    localparam int MAX_ITEMS_DEF = 32;

    typedef enum logic [5:0] {
        ST_LOAD, ST_S_INIT, ST_S_RDJ, ST_S_RDJM, ST_S_CAPB, ST_S_MUL, ST_S_CMP,
        ST_S_WRJ, ST_S_WRJM, ST_S_NEXT, ST_R_INIT, ST_E_RD, ST_E_RD2, ST_E_CAP,
        ST_D_CHK, ST_D_STEP, ST_T_MUL, ST_T_ADD, ST_B_MUL, ST_B_CMP, ST_REC,
        ST_C_RD, ST_C_WR, ST_DESC, ST_UNDO, ST_RET, ST_RET_RD, ST_RET_RD2,
        ST_RET_CAP, ST_RET_MUL, ST_TW_INIT, ST_TW_RD, ST_TW_MUL, ST_TW_ACC,
        ST_EM_INIT, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
    } t_state;

    typedef enum logic [5:0] {
        OP_NOP, OP_S_INIT, OP_RD_J, OP_RD_JM, OP_CAP_B, OP_S_MUL, OP_WR_J,
        OP_WR_JM, OP_S_NEXT, OP_R_INIT, OP_RD_LVL, OP_RD_NXT, OP_RD_NXT_C,
        OP_CAP_NXT, OP_DIV_INIT, OP_DIV_STEP, OP_T_MUL, OP_T_ADD, OP_B_MUL,
        OP_B_CMP, OP_REC, OP_CP_RD, OP_CP_WR, OP_DESC, OP_UNDO, OP_RET,
        OP_TW_INIT, OP_K_CLR, OP_K_RD, OP_TW_MUL, OP_TW_ACC, OP_EM_LD, OP_EM_ACC
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic n_small;
        logic sort_last;
        logic swap;
        logic div_skip;
        logic div_last;
        logic go;
        logic leaf;
        logic better;
        logic k_last;
        logic c_zero;
        logic lvl_zero;
    } t_st;

endpackage

@@ hw/rtl/bkbb_if.sv @@
interface bkbb_in_if import bkbb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [W_W-1:0]   item_weight;
    logic [V_W-1:0]   item_value;
    logic [L_W-1:0]   copy_limit;
    logic             last_item;

    modport source (output valid, item_weight, item_value, copy_limit, last_item,
                    input ready);
    modport sink (input valid, item_weight, item_value, copy_limit, last_item,
                  output ready);
endinterface

interface bkbb_out_if import bkbb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] sorted_position;
    logic [W_W-1:0]   out_weight;
    logic [V_W-1:0]   out_value;
    logic [L_W-1:0]   chosen_count;
    logic [TV_W-1:0]  best_total_value;
    logic [CAP_W-1:0] best_total_weight;
    logic             last_result;

    modport source (output valid, sorted_position, out_weight, out_value,
                    chosen_count, best_total_value, best_total_weight, last_result,
                    input ready);
    modport sink (input valid, sorted_position, out_weight, out_value,
                  chosen_count, best_total_value, best_total_weight, last_result,
                  output ready);
endinterface

@@ hw/rtl/bkbb_ram.sv @@
module bkbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/bkbb_ctrl.sv @@
module bkbb_ctrl import bkbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_st  i_st,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EM_WAIT);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_cmd.load = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) n_state = ST_S_INIT;
            end
            ST_S_INIT: begin
                o_cmd.op = OP_S_INIT;
                n_state  = i_st.n_small ? ST_R_INIT : ST_S_RDJ;
            end
            ST_S_RDJ:  begin o_cmd.op = OP_RD_J;  n_state = ST_S_RDJM; end
            ST_S_RDJM: begin o_cmd.op = OP_RD_JM; n_state = ST_S_CAPB; end
            ST_S_CAPB: begin o_cmd.op = OP_CAP_B; n_state = ST_S_MUL;  end
            ST_S_MUL:  begin o_cmd.op = OP_S_MUL; n_state = ST_S_CMP;  end
            ST_S_CMP:  n_state = i_st.swap ? ST_S_WRJ : ST_S_NEXT;
            ST_S_WRJ:  begin o_cmd.op = OP_WR_J;  n_state = ST_S_WRJM; end
            ST_S_WRJM: begin o_cmd.op = OP_WR_JM; n_state = ST_S_NEXT; end
            ST_S_NEXT: begin
                o_cmd.op = OP_S_NEXT;
                n_state  = i_st.sort_last ? ST_R_INIT : ST_S_RDJ;
            end
            ST_R_INIT: begin o_cmd.op = OP_R_INIT;  n_state = ST_E_RD;  end
            ST_E_RD:   begin o_cmd.op = OP_RD_LVL;  n_state = ST_E_RD2; end
            ST_E_RD2:  begin o_cmd.op = OP_RD_NXT;  n_state = ST_E_CAP; end
            ST_E_CAP:  begin o_cmd.op = OP_CAP_NXT; n_state = ST_D_CHK; end
            ST_D_CHK: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = i_st.div_skip ? ST_T_MUL : ST_D_STEP;
            end
            ST_D_STEP: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_st.div_last) n_state = ST_T_MUL;
            end
            ST_T_MUL: begin o_cmd.op = OP_T_MUL; n_state = ST_T_ADD; end
            ST_T_ADD: begin o_cmd.op = OP_T_ADD; n_state = ST_B_MUL; end
            ST_B_MUL: begin o_cmd.op = OP_B_MUL; n_state = ST_B_CMP; end
            ST_B_CMP: begin
                o_cmd.op = OP_B_CMP;
                priority if (!i_st.go) n_state = ST_UNDO;
                else if (i_st.leaf)     n_state = ST_REC;
                else                    n_state = ST_DESC;
            end
            ST_REC: begin
                o_cmd.op = OP_REC;
                n_state  = i_st.better ? ST_C_RD : ST_UNDO;
            end
            ST_C_RD: begin o_cmd.op = OP_CP_RD; n_state = ST_C_WR; end
            ST_C_WR: begin
                o_cmd.op = OP_CP_WR;
                n_state  = i_st.k_last ? ST_UNDO : ST_C_RD;
            end
            ST_DESC: begin o_cmd.op = OP_DESC; n_state = ST_E_RD; end
            ST_UNDO: begin
                o_cmd.op = OP_UNDO;
                priority if (!i_st.c_zero) n_state = ST_T_MUL;
                else if (i_st.lvl_zero)     n_state = ST_TW_INIT;
                else                        n_state = ST_RET;
            end
            ST_RET:     begin o_cmd.op = OP_RET;       n_state = ST_RET_RD;  end
            ST_RET_RD:  begin o_cmd.op = OP_RD_LVL;    n_state = ST_RET_RD2; end
            ST_RET_RD2: begin o_cmd.op = OP_RD_NXT_C;  n_state = ST_RET_CAP; end
            ST_RET_CAP: begin o_cmd.op = OP_CAP_NXT;   n_state = ST_RET_MUL; end
            ST_RET_MUL: begin o_cmd.op = OP_T_MUL;     n_state = ST_UNDO;    end
            ST_TW_INIT: begin o_cmd.op = OP_TW_INIT;   n_state = ST_TW_RD;   end
            ST_TW_RD:   begin o_cmd.op = OP_K_RD;      n_state = ST_TW_MUL;  end
            ST_TW_MUL:  begin o_cmd.op = OP_TW_MUL;    n_state = ST_TW_ACC;  end
            ST_TW_ACC: begin
                o_cmd.op = OP_TW_ACC;
                n_state  = i_st.k_last ? ST_EM_INIT : ST_TW_RD;
            end
            ST_EM_INIT: begin o_cmd.op = OP_K_CLR; n_state = ST_EM_RD;   end
            ST_EM_RD:   begin o_cmd.op = OP_K_RD;  n_state = ST_EM_LD;   end
            ST_EM_LD:   begin o_cmd.op = OP_EM_LD; n_state = ST_EM_WAIT; end
            ST_EM_WAIT: begin
                if (i_out_ready) begin
                    o_cmd.op = OP_EM_ACC;
                    n_state  = i_st.k_last ? ST_LOAD : ST_EM_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end
endmodule

@@ hw/rtl/bkbb_dp.sv @@
module bkbb_dp import bkbb_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_capacity,
    input  logic [W_W-1:0]   i_item_weight,
    input  logic [V_W-1:0]   i_item_value,
    input  logic [L_W-1:0]   i_copy_limit,
    output t_st              o_st,
    output logic [POS_W-1:0] o_sorted_position,
    output logic [W_W-1:0]   o_out_weight,
    output logic [V_W-1:0]   o_out_value,
    output logic [L_W-1:0]   o_chosen_count,
    output logic [TV_W-1:0]  o_best_total_value,
    output logic [CAP_W-1:0] o_best_total_weight,
    output logic             o_last_result
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = IW + 1;
    localparam int PW = 2 * W_W;
    localparam int M1_W = TV_W + W_W;
    localparam int M2_W = CAP_W + V_W;
    localparam int SUM_W = M1_W + 1;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_n;
    logic [IW-1:0]    r_i, r_j, r_k, r_lvl, r_best_lvl;
    logic [IT_W-1:0]  r_a, r_b;
    logic [PW-1:0]    r_p1, r_p2;
    logic [W_W-1:0]   r_cw, r_nw;
    logic [V_W-1:0]   r_cv, r_nv;
    logic [L_W-1:0]   r_cl, r_c, r_q;
    logic [CAP_W-1:0] r_rem, r_pv, r_pw, r_rc, r_tw;
    logic [2:0]       r_step;
    logic [TV_W-1:0]  r_rv, r_bv;
    logic             r_found;
    logic [M1_W-1:0]  r_m1, r_m3;
    logic [M2_W-1:0]  r_m2;

    logic [IT_W-1:0]  it_rd, it_wdata;
    logic [IW-1:0]    it_waddr, it_raddr, cnt_raddr, best_raddr;
    logic             it_we, cnt_we, best_we;
    logic [L_W-1:0]   cnt_rd, best_rd, best_wdata, best_cnt;
    logic             is_last;
    logic [CAP_W-1:0] div_shift;
    logic             div_ge;
    logic [L_W-1:0]   n_q;

    bkbb_ram #(.WIDTH(IT_W), .DEPTH(MAX_ITEMS)) u_items (
        .i_clk(i_clk), .i_we(it_we), .i_waddr(it_waddr), .i_wdata(it_wdata),
        .i_raddr(it_raddr), .o_rdata(it_rd));
    bkbb_ram #(.WIDTH(L_W), .DEPTH(MAX_ITEMS)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(r_lvl), .i_wdata(r_c),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rd));
    bkbb_ram #(.WIDTH(L_W), .DEPTH(MAX_ITEMS)) u_best (
        .i_clk(i_clk), .i_we(best_we), .i_waddr(r_k), .i_wdata(best_wdata),
        .i_raddr(best_raddr), .o_rdata(best_rd));

    assign is_last   = ({1'b0, r_lvl} + CW'(1)) >= r_n;
    assign div_shift = CAP_W'(r_cw) << r_step;
    assign div_ge    = r_rem >= div_shift;
    assign n_q       = r_q | (L_W'(div_ge) << r_step);
    // best counts are only written once a solution is recorded
    assign best_cnt  = r_found ? best_rd : '0;
    assign best_wdata = (r_k <= r_best_lvl) ? cnt_rd : '0;

    always_comb begin
        o_st.n_small   = r_n < CW'(2);
        o_st.sort_last = ({1'b0, r_j} == {1'b0, r_i} + CW'(1)) &&
                         ({1'b0, r_i} + CW'(2) >= r_n);
        o_st.swap      = r_p1 > r_p2;
        o_st.div_skip  = (r_cw == '0) || (r_rc >= {r_cw, 8'd0});
        o_st.div_last  = (r_step == 3'd0);
        if (is_last) begin
            o_st.go = r_rv > r_bv;
        end else if (r_nw == '0) begin
            o_st.go = 1'b1;
        end else begin
            o_st.go = (SUM_W'(r_m1) + SUM_W'(r_m2)) > SUM_W'(r_m3);
        end
        o_st.leaf      = is_last || (r_rc == '0);
        o_st.better    = r_rv > r_bv;
        o_st.k_last    = ({1'b0, r_k} + CW'(1)) == r_n;
        o_st.c_zero    = (r_c == '0);
        o_st.lvl_zero  = (r_lvl == '0);
    end

    always_comb begin
        it_we      = 1'b0;
        it_waddr   = r_n[IW-1:0];
        it_wdata   = {i_item_weight, i_item_value, i_copy_limit};
        it_raddr   = r_k;
        cnt_raddr  = r_lvl;
        best_raddr = r_k;
        cnt_we     = (i_cmd.op == OP_B_CMP) && o_st.go;
        best_we    = (i_cmd.op == OP_CP_WR);
        if (i_cmd.load && (r_n < CW'(MAX_ITEMS))) begin
            it_we = 1'b1;
        end
        unique case (i_cmd.op)
            OP_RD_J:  it_raddr = r_j;
            OP_RD_JM: it_raddr = r_j - IW'(1);
            OP_WR_J: begin
                it_we = 1'b1; it_waddr = r_j; it_wdata = r_b;
            end
            OP_WR_JM: begin
                it_we = 1'b1; it_waddr = r_j - IW'(1); it_wdata = r_a;
            end
            OP_RD_LVL: it_raddr = r_lvl;
            OP_RD_NXT, OP_RD_NXT_C: it_raddr = r_lvl + IW'(1);
            OP_CP_RD: cnt_raddr = r_k;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= '0;
            r_n     <= '0;
            r_found <= 1'b0;
            r_bv    <= '0;
            r_rv    <= '0;
            r_rc    <= '0;
            r_lvl   <= '0;
            r_k     <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_capacity;
            if (i_cmd.load && (r_n < CW'(MAX_ITEMS))) r_n <= r_n + CW'(1);
            unique case (i_cmd.op)
                OP_S_INIT: begin
                    r_i <= '0;
                    r_j <= IW'(r_n - CW'(1));
                end
                OP_RD_JM: r_a <= it_rd;
                OP_CAP_B: r_b <= it_rd;
                OP_S_MUL: begin
                    r_p1 <= PW'(r_a[L_W +: V_W]) * PW'(r_b[IT_W-1 -: W_W]);
                    r_p2 <= PW'(r_b[L_W +: V_W]) * PW'(r_a[IT_W-1 -: W_W]);
                end
                OP_S_NEXT: begin
                    if ({1'b0, r_j} > {1'b0, r_i} + CW'(1)) begin
                        r_j <= r_j - IW'(1);
                    end else begin
                        r_i <= r_i + IW'(1);
                        r_j <= IW'(r_n - CW'(1));
                    end
                end
                OP_R_INIT: begin
                    r_lvl   <= '0;
                    r_rv    <= '0;
                    r_rc    <= r_cap;
                    r_bv    <= '0;
                    r_found <= 1'b0;
                end
                OP_RD_NXT, OP_RD_NXT_C: begin
                    r_cw <= it_rd[IT_W-1 -: W_W];
                    r_cv <= it_rd[L_W +: V_W];
                    r_cl <= it_rd[L_W-1:0];
                    if (i_cmd.op == OP_RD_NXT_C) r_c <= cnt_rd;
                end
                OP_CAP_NXT: begin
                    r_nw <= it_rd[IT_W-1 -: W_W];
                    r_nv <= it_rd[L_W +: V_W];
                end
                OP_DIV_INIT: begin
                    // quotient beyond 255 means the copy limit decides
                    if (o_st.div_skip) begin
                        r_c <= r_cl;
                    end else begin
                        r_rem  <= r_rc;
                        r_q    <= '0;
                        r_step <= 3'd7;
                    end
                end
                OP_DIV_STEP: begin
                    if (div_ge) r_rem <= r_rem - div_shift;
                    r_q    <= n_q;
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) r_c <= (n_q < r_cl) ? n_q : r_cl;
                end
                OP_T_MUL: begin
                    r_pv <= CAP_W'(r_c) * CAP_W'(r_cv);
                    r_pw <= CAP_W'(r_c) * CAP_W'(r_cw);
                end
                OP_T_ADD: begin
                    r_rv <= r_rv + TV_W'(r_pv);
                    r_rc <= r_rc - r_pw;
                end
                OP_B_MUL: begin
                    r_m1 <= M1_W'(r_rv) * M1_W'(r_nw);
                    r_m2 <= M2_W'(r_rc) * M2_W'(r_nv);
                    r_m3 <= M1_W'(r_bv) * M1_W'(r_nw);
                end
                OP_REC: begin
                    if (o_st.better) begin
                        r_bv       <= r_rv;
                        r_found    <= 1'b1;
                        r_best_lvl <= r_lvl;
                        r_k        <= '0;
                    end
                end
                OP_CP_WR: r_k <= r_k + IW'(1);
                OP_DESC:  r_lvl <= r_lvl + IW'(1);
                OP_UNDO: begin
                    r_rv <= r_rv - TV_W'(r_pv);
                    r_rc <= r_rc + r_pw;
                    if (r_c != '0) r_c <= r_c - L_W'(1);
                end
                OP_RET: r_lvl <= r_lvl - IW'(1);
                OP_TW_INIT: begin
                    r_k  <= '0;
                    r_tw <= '0;
                end
                OP_K_CLR:  r_k <= '0;
                OP_TW_MUL: r_pw <= CAP_W'(best_cnt) * CAP_W'(it_rd[IT_W-1 -: W_W]);
                OP_TW_ACC: begin
                    r_tw <= r_tw + r_pw;
                    r_k  <= r_k + IW'(1);
                end
                OP_EM_LD: begin
                    o_sorted_position   <= POS_W'(r_k);
                    o_out_weight        <= it_rd[IT_W-1 -: W_W];
                    o_out_value         <= it_rd[L_W +: V_W];
                    o_chosen_count      <= best_cnt;
                    o_best_total_value  <= r_bv;
                    o_best_total_weight <= r_tw;
                    o_last_result       <= o_st.k_last;
                end
                OP_EM_ACC: begin
                    r_k <= r_k + IW'(1);
                    if (o_st.k_last) r_n <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hw/rtl/bounded_knapsack_branch_bound.sv @@
// Load: one item per cycle, ready is high whenever the block is loading.
// The item marked last starts a sort (n*(n-1)/2 compares, each may swap)
// and a depth-first search that enters a level, with a divide where needed,
// tries counts there, leaves it, and copies out the counts of each new best.
// Results: the weight total is summed first, then one per item, held until ready.
// Synchronous active-low reset returns to loading with an empty set.
module bounded_knapsack_branch_bound import bkbb_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_capacity,
    bkbb_in_if.sink          i_in,
    bkbb_out_if.source       o_out
);
    t_cmd cmd;
    t_st  st;

    bkbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_st        (st),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_item),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    bkbb_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_capacity      (i_cfg_capacity),
        .i_item_weight       (i_in.item_weight),
        .i_item_value        (i_in.item_value),
        .i_copy_limit        (i_in.copy_limit),
        .o_st                (st),
        .o_sorted_position   (o_out.sorted_position),
        .o_out_weight        (o_out.out_weight),
        .o_out_value         (o_out.out_value),
        .o_chosen_count      (o_out.chosen_count),
        .o_best_total_value  (o_out.best_total_value),
        .o_best_total_weight (o_out.best_total_weight),
        .o_last_result       (o_out.last_result)
    );
endmodule

@@ hw/rtl/bkbb_chk.sv @@
module bkbb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last,
    input logic [5:0] i_out_pos
);
    // no item is taken while results are being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken during result delivery");

    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("loading continued after last item");

    a_end_of_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("no return to loading after final result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pos)))
        else $error("stalled result changed");
endmodule

bind bounded_knapsack_branch_bound bkbb_chk u_bkbb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_item),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last_result),
    .i_out_pos   (o_out.sorted_position)
);
